// File: hdl/clamped_quadrature_counter_unit_macros.svh
// ----------------------------------------------------------------------------
// Clamped quadrature counter assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_QUADRATURE_COUNTER_UNIT_MACROS_SVH
`define CLAMPED_QUADRATURE_COUNTER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CQC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CQC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cqc_pkg.sv
// ----------------------------------------------------------------------------
// Clamped quadrature counter package
// Widths, reset values, codes, types and the clamp function.
// ----------------------------------------------------------------------------
package cqc_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int ONE_FIX       = 1 << FRACTION_BITS;

    localparam int COUNT_W     = 32;
    localparam int STEP_W      = 16;
    localparam int DELTA_W     = STEP_W + 1;
    localparam int SUM_W       = COUNT_W + 2;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;

    // rounded half away from zero: -1.2, 6.6, 0.1, 3.14
    localparam logic signed [COUNT_W-1:0] COUNT_MIN_RST =
        COUNT_W'(-((12 * ONE_FIX + 5) / 10));
    localparam logic signed [COUNT_W-1:0] COUNT_MAX_RST =
        COUNT_W'((66 * ONE_FIX + 5) / 10);
    localparam logic [STEP_W-1:0] COUNT_STEP_RST =
        STEP_W'((1 * ONE_FIX + 5) / 10);
    localparam logic signed [COUNT_W-1:0] COUNT_VALUE_RST =
        COUNT_W'((314 * ONE_FIX + 50) / 100);

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_PRESET = 2'd1,
        OP_ACK    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_MIN  = 2'd0,
        REG_MAX  = 2'd1,
        REG_STEP = 2'd2,
        REG_DIR  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] lower_bound;
        logic signed [COUNT_W-1:0] upper_bound;
        logic [STEP_W-1:0]         step_size;
        logic                      reverse_direction;
    } cfg_t;

    typedef struct packed {
        op_t                       operation;
        logic                      pin_a;
        logic                      pin_b;
        logic signed [COUNT_W-1:0] preset_value;
    } item_t;

    // minimum tested first, then maximum
    function automatic logic signed [COUNT_W-1:0] clamp_count(
        input logic signed [SUM_W-1:0]   x,
        input logic signed [COUNT_W-1:0] lo,
        input logic signed [COUNT_W-1:0] hi
    );
        logic signed [SUM_W-1:0]   lo_w;
        logic signed [SUM_W-1:0]   hi_w;
        logic signed [COUNT_W-1:0] r;
        lo_w = SUM_W'(lo);
        hi_w = SUM_W'(hi);
        if (x < lo_w)
        begin
            r = lo;
        end
        else if (x > hi_w)
        begin
            r = hi;
        end
        else
        begin
            r = x[COUNT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/cqc_regs.sv
// ----------------------------------------------------------------------------
// Configuration register file
// APB-style write and read access to the four counter settings.
// ----------------------------------------------------------------------------
module cqc_regs
    import cqc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MIN:  cfg_next.lower_bound       = pwdata;
                REG_MAX:  cfg_next.upper_bound       = pwdata;
                REG_STEP: cfg_next.step_size         = pwdata[STEP_W-1:0];
                REG_DIR:  cfg_next.reverse_direction = pwdata[0];
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MIN:  prdata = cfg_reg.lower_bound;
            REG_MAX:  prdata = cfg_reg.upper_bound;
            REG_STEP: prdata = DATA_W'(cfg_reg.step_size);
            REG_DIR:  prdata = DATA_W'(cfg_reg.reverse_direction);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower_bound       <= COUNT_MIN_RST;
            cfg_reg.upper_bound       <= COUNT_MAX_RST;
            cfg_reg.step_size         <= COUNT_STEP_RST;
            cfg_reg.reverse_direction <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/cqc_in_reg.sv
// ----------------------------------------------------------------------------
// Input request register
// Holds one request from the slave side until the core takes it.
// ----------------------------------------------------------------------------
module cqc_in_reg
    import cqc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,  // pin_a, pin_b, preset_value[31:0], pad
    input  logic [IN_TUSER_W-1:0] s_tuser,  // operation[1:0]
    output logic                  item_valid,
    output item_t                 item,
    input  logic                  item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign s_tready   = !valid_reg || item_take;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load || (valid_reg && !item_take);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.operation    <= op_t'(s_tuser);
            item_reg.pin_a        <= s_tdata[0];
            item_reg.pin_b        <= s_tdata[1];
            item_reg.preset_value <= s_tdata[COUNT_W+1:2];
        end
    end

endmodule

// File: hdl/cqc_core.sv
// ----------------------------------------------------------------------------
// Counter core
// Quadrature decode, two clamped adds, sticky flag and the result register.
// ----------------------------------------------------------------------------
module cqc_core
    import cqc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   item_valid,
    input  item_t                  item,
    output logic                   item_take,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata  // count[31:0], changed, pad
);

    logic signed [COUNT_W-1:0] count_value_reg;
    logic signed [COUNT_W-1:0] count_value_next;
    logic signed [COUNT_W-1:0] reported_reg;
    logic signed [COUNT_W-1:0] reported_next;
    logic                      changed_reg;
    logic                      changed_next;
    logic                      last_a_reg;
    logic                      last_a_next;
    logic                      last_b_reg;
    logic                      last_b_next;
    logic                      last_eq_reg;
    logic                      last_eq_next;

    logic                      out_valid_reg;
    logic signed [COUNT_W-1:0] out_count_reg;
    logic                      out_changed_reg;
    logic                      flag_out;

    logic                      eq;
    logic signed [DELTA_W-1:0] step_s;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum1;
    logic signed [SUM_W-1:0]   sum2;
    logic signed [COUNT_W-1:0] stage1;
    logic signed [COUNT_W-1:0] stage2;

    assign item_take = item_valid && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_TDATA_W'({out_changed_reg, out_count_reg});

    always_comb
    begin
        eq     = (item.pin_a == item.pin_b);
        step_s = $signed({1'b0, cfg.step_size});
        if (cfg.reverse_direction)
        begin
            step_s = -step_s;
        end
        delta  = eq ? step_s : -step_s;
        sum1   = SUM_W'(count_value_reg) + SUM_W'(delta);
        stage1 = clamp_count(sum1, cfg.lower_bound, cfg.upper_bound);
        sum2   = SUM_W'(stage1) + SUM_W'(delta);
        stage2 = clamp_count(sum2, cfg.lower_bound, cfg.upper_bound);
    end

    always_comb
    begin
        count_value_next = count_value_reg;
        reported_next    = reported_reg;
        changed_next     = changed_reg;
        last_a_next      = last_a_reg;
        last_b_next      = last_b_reg;
        last_eq_next     = last_eq_reg;
        flag_out         = changed_reg;
        case (item.operation)
            OP_SAMPLE:
            begin
                if (item.pin_a != last_a_reg)
                begin
                    last_a_next = item.pin_a;
                    if (item.pin_b != last_b_reg)
                    begin
                        last_b_next      = item.pin_b;
                        last_eq_next     = eq;
                        count_value_next = (eq != last_eq_reg) ? stage2 : stage1;
                    end
                end
                if (count_value_next != reported_reg)
                begin
                    reported_next = count_value_next;
                    changed_next  = 1'b1;
                end
                flag_out = changed_next;
            end
            OP_PRESET:
            begin
                count_value_next = clamp_count(SUM_W'(item.preset_value),
                                               cfg.lower_bound, cfg.upper_bound);
            end
            OP_ACK:
            begin
                changed_next = 1'b0;
            end
            default:
            begin
                flag_out = changed_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_value_reg <= COUNT_VALUE_RST;
            reported_reg    <= '0;
            changed_reg     <= 1'b0;
            last_a_reg      <= 1'b0;
            last_b_reg      <= 1'b0;
            last_eq_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                count_value_reg <= count_value_next;
                reported_reg    <= reported_next;
                changed_reg     <= changed_next;
                last_a_reg      <= last_a_next;
                last_b_reg      <= last_b_next;
                last_eq_reg     <= last_eq_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            out_count_reg   <= count_value_next;
            out_changed_reg <= flag_out;
        end
    end

endmodule

// File: hdl/clamped_quadrature_counter_unit.sv
// ----------------------------------------------------------------------------
// Clamped quadrature counter unit
// Rotary encoder counter with clamped steps, preset and sticky change flag.
// ----------------------------------------------------------------------------
//  channel   | signals                             | content
//  ----------+-------------------------------------+-----------------------------
//  s_ (in)   | tvalid tready tdata[39:0] tuser[1:0]| pins A/B, preset; operation
//  m_ (out)  | tvalid tready tdata[39:0]           | count, changed flag
//  APB cfg   | psel penable pwrite paddr[3:0] ...  | min, max, step, direction
//
//  One request per cycle sustained while results are taken; a request passes
//  the input register and then the result register before its result is valid.
//  Input register, then decode and two clamped adds into the result register.
//  A stalled result holds; the input register still takes one request.
//  rst_n resets the control state at once (item and result data are not reset); no clearing pass.
// ----------------------------------------------------------------------------
module clamped_quadrature_counter_unit
    import cqc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // pin_a, pin_b, preset_value[31:0], pad
    input  logic [IN_TUSER_W-1:0]  s_tuser,  // operation[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // count[31:0], changed, pad
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  item_take;

    cqc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cqc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    cqc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// File: hdl/cqc_checker.sv
// ----------------------------------------------------------------------------
// Clamped quadrature counter port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "clamped_quadrature_counter_unit_macros.svh"

module cqc_checker
    import cqc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   psel,
    input logic                   penable,
    input logic                   pwrite,
    input logic [ADDR_W-1:0]      paddr,
    input logic [DATA_W-1:0]      pwdata,
    input logic [DATA_W-1:0]      prdata,
    input logic                   pready
);

    logic sel_min;
    logic sel_dir;
    logic wr_min;

    assign sel_min = (paddr[ADDR_W-1:2] == REG_MIN);
    assign sel_dir = (paddr[ADDR_W-1:2] == REG_DIR);
    assign wr_min  = psel && penable && pwrite && pready && sel_min;

    `CQC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `CQC_ASSERT_NOW(a_in_free, m_tready || !m_tvalid, s_tready, "input blocked with free output")
    `CQC_ASSERT_NOW(a_min_readback, $past(wr_min) && sel_min, prdata == $past(pwdata), "min readback")
    `CQC_ASSERT_NOW(a_dir_width, sel_dir, prdata[DATA_W-1:1] == '0, "direction wider than one bit")

endmodule

bind clamped_quadrature_counter_unit cqc_checker u_cqc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

// File: tb/clamped_quadrature_counter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clamped quadrature counter unit testbench
// Streams pin samples, presets, acknowledges and unused codes into the counter,
// predicts every result from its own copy of the counter state, and checks count
// and changed flag per result. Settings change between phases over APB, among
// them full range, crossed bounds, zero step and a single-point window.
// ----------------------------------------------------------------------------
module clamped_quadrature_counter_unit_tb;

    import cqc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int GAP_PCT   = 18;
    localparam int HOLD_LEN  = 150;
    localparam int PHASE_LEN = 110;

    typedef struct {
        logic [1:0]  op;
        logic        pin_a;
        logic        pin_b;
        logic [31:0] preset;
    } request_rec;

    typedef struct {
        logic [31:0] count;
        logic        changed;
    } count_rec;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // pin_a, pin_b, preset_value[31:0], pad
    logic [IN_TUSER_W-1:0]  s_tuser = '0;   // operation[1:0]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // count[31:0], changed, pad
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]      pwdata = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    // counter copy and its settings
    longint      lim_lo;
    longint      lim_hi;
    logic [15:0] step_mag;
    logic        step_rev;
    longint      q_count;
    longint      q_reported;
    logic        q_flag;
    logic        q_last_a;
    logic        q_last_b;
    logic        q_last_eq;

    request_rec pending_q[$];
    count_rec   count_expect_q[$];
    request_rec in_flight;
    request_rec nxt_req;
    count_rec   want;
    int         issued_cnt = 0;
    int         accepted_cnt = 0;
    int         err_cnt = 0;
    bit         src_gaps = 1'b1;
    bit         sink_gaps = 1'b1;
    int         hold_kick = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         walk_pos = 0;
    int         walk_dir = 1;

    clamped_quadrature_counter_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint clamp_to_bounds(input longint x);
        if (x < lim_lo)
        begin
            return lim_lo;
        end
        if (x > lim_hi)
        begin
            return lim_hi;
        end
        return x;
    endfunction

    task automatic advance_counter(input request_rec r);
        longint   s;
        longint   d;
        logic     eq;
        count_rec res;
        res.changed = q_flag;
        case (r.op)
            OP_SAMPLE:
            begin
                if (r.pin_a != q_last_a)
                begin
                    q_last_a = r.pin_a;
                    if (r.pin_b != q_last_b)
                    begin
                        eq = (r.pin_a == r.pin_b);
                        s = step_rev ? -longint'(step_mag) : longint'(step_mag);
                        d = eq ? s : -s;
                        q_last_b = r.pin_b;
                        q_count = clamp_to_bounds(q_count + d);
                        if (eq != q_last_eq)
                        begin
                            q_count = clamp_to_bounds(q_count + d);
                        end
                        q_last_eq = eq;
                    end
                end
                if (q_count != q_reported)
                begin
                    q_reported = q_count;
                    q_flag = 1'b1;
                end
                res.changed = q_flag;
            end
            OP_PRESET:
            begin
                q_count = clamp_to_bounds(longint'($signed(r.preset)));
                res.changed = q_flag;
            end
            OP_ACK:
            begin
                res.changed = q_flag;
                q_flag = 1'b0;
            end
            default:
            begin
            end
        endcase
        res.count = q_count[31:0];
        count_expect_q.push_back(res);
    endtask

    task automatic post(input logic [1:0] op, input logic a, input logic b,
                        input logic [31:0] p);
        request_rec r;
        r.op = op;
        r.pin_a = a;
        r.pin_b = b;
        r.preset = p;
        pending_q.push_back(r);
        issued_cnt++;
    endtask

    task automatic post_random();
        int          pick;
        longint      base;
        longint      span;
        logic [31:0] p;
        pick = $urandom_range(0, 99);
        p = $urandom;
        if (pick < 50)
        begin
            // walk the Gray sequence, turning around now and then
            if ($urandom_range(0, 9) == 0)
            begin
                walk_dir = -walk_dir;
            end
            walk_pos = (walk_pos + walk_dir + 4) % 4;
            post(OP_SAMPLE, walk_pos[1], walk_pos[1] ^ walk_pos[0], p);
        end
        else if (pick < 68)
        begin
            post(OP_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), p);
        end
        else if (pick < 82)
        begin
            post(OP_ACK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), p);
        end
        else if (pick < 95)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                end
                1:
                begin
                    base = $urandom_range(0, 1) ? lim_lo : lim_hi;
                    span = 3 * longint'(step_mag) + 5;
                    p = 32'(base + longint'($urandom_range(0, 32'(2 * span))) - span);
                end
                default:
                begin
                    p = 32'($signed($urandom_range(0, 4000)) - 2000);
                end
            endcase
            post(OP_PRESET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), p);
        end
        else
        begin
            post(OP_UNUSED, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), p);
        end
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN:  lim_lo = longint'($signed(v));
            REG_MAX:  lim_hi = longint'($signed(v));
            REG_STEP: step_mag = v[15:0];
            REG_DIR:  step_rev = v[0];
            default:
            begin
            end
        endcase
    endtask

    task automatic configure(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [15:0] st, input logic rev);
        apb_write(REG_MIN, lo);
        apb_write(REG_MAX, hi);
        apb_write(REG_STEP, {16'd0, st});
        apb_write(REG_DIR, {31'd0, rev});
    endtask

    task automatic drain();
        while (accepted_cnt != issued_cnt || count_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // request side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                advance_counter(in_flight);
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_q.size() > 0 &&
                    !(src_gaps && $urandom_range(0, 99) < GAP_PCT))
                begin
                    nxt_req = pending_q.pop_front();
                    in_flight = nxt_req;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'd0, nxt_req.preset, nxt_req.pin_b, nxt_req.pin_a};
                    s_tuser  <= nxt_req.op;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (count_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result count %0d changed %0b", $time,
                             $signed(m_tdata[31:0]), m_tdata[32]);
                    err_cnt++;
                end
                else
                begin
                    want = count_expect_q.pop_front();
                    if (m_tdata[31:0] !== want.count)
                    begin
                        $display("%0t: count expected %0d actual %0d", $time,
                                 $signed(want.count), $signed(m_tdata[31:0]));
                        err_cnt++;
                    end
                    if (m_tdata[32] !== want.changed)
                    begin
                        $display("%0t: changed expected %0b actual %0b", $time,
                                 want.changed, m_tdata[32]);
                        err_cnt++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_kick != hold_seen)
            begin
                hold_seen = hold_kick;
                hold_left = HOLD_LEN;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= !(sink_gaps && $urandom_range(0, 99) < GAP_PCT);
            end
        end
    end

    initial
    begin
        int          ph;
        int          k;
        logic [31:0] lo;
        logic [31:0] hi;
        lim_lo     = longint'(COUNT_MIN_RST);
        lim_hi     = longint'(COUNT_MAX_RST);
        step_mag   = COUNT_STEP_RST;
        step_rev   = 1'b0;
        q_count    = longint'(COUNT_VALUE_RST);
        q_reported = 0;
        q_flag     = 1'b0;
        q_last_a   = 1'b0;
        q_last_b   = 1'b0;
        q_last_eq  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests under the reset settings
        post(OP_SAMPLE, 1'b0, 1'b0, 32'd0);
        post(OP_SAMPLE, 1'b1, 1'b1, 32'd0);
        post(OP_SAMPLE, 1'b1, 1'b0, 32'd0);
        post(OP_SAMPLE, 1'b0, 1'b0, 32'hffff_ffff);
        post(OP_SAMPLE, 1'b1, 1'b0, 32'd0);
        post(OP_SAMPLE, 1'b0, 1'b1, 32'd0);
        post(OP_ACK, 1'b0, 1'b0, 32'd0);
        post(OP_ACK, 1'b1, 1'b1, 32'hffff_ffff);
        post(OP_PRESET, 1'b0, 1'b0, 32'h7fff_ffff);
        post(OP_ACK, 1'b0, 1'b0, 32'd0);
        post(OP_SAMPLE, 1'b0, 1'b1, 32'h5555_aaaa);
        post(OP_PRESET, 1'b1, 1'b1, 32'h8000_0000);
        post(OP_PRESET, 1'b0, 1'b0, 32'hffff_ffff);
        post(OP_PRESET, 1'b0, 1'b0, 32'd0);
        post(OP_UNUSED, 1'b1, 1'b0, 32'h1234_5678);
        post(OP_UNUSED, 1'b0, 1'b1, 32'hedcb_a987);
        post(OP_PRESET, 1'b0, 1'b0, 32'd1680);
        for (k = 0; k < 8; k++)
        begin
            walk_pos = (walk_pos + 1) % 4;
            post(OP_SAMPLE, walk_pos[1], walk_pos[1] ^ walk_pos[0], 32'd0);
        end
        drain();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: configure(32'h8000_0000, 32'h7fff_ffff, 16'hffff, 1'b0);
                1: configure(32'd1000, -32'sd1000, 16'd300, 1'b1);
                2: configure(-32'sd5000, 32'd5000, 16'd0, 1'b0);
                3: configure(32'd777, 32'd777, 16'($urandom), 1'b1);
                default:
                begin
                    lo = $urandom;
                    hi = $urandom;
                    if ($signed(lo) > $signed(hi))
                    begin
                        {lo, hi} = {hi, lo};
                    end
                    if ($urandom_range(0, 1))
                    begin
                        hi = 32'($signed(lo) + $urandom_range(0, 20000));
                        if ($signed(hi) < $signed(lo))
                        begin
                            hi = 32'h7fff_ffff;
                        end
                    end
                    configure(lo, hi, 16'($urandom_range(0, 2000)),
                              1'($urandom_range(0, 1)));
                end
            endcase
            src_gaps  = (ph != 4);
            sink_gaps = (ph != 4);
            if (ph == 0)
            begin
                post(OP_PRESET, 1'b0, 1'b0, 32'h7fff_ff00);
                post(OP_PRESET, 1'b0, 1'b0, 32'h8000_0100);
            end
            for (k = 0; k < PHASE_LEN; k++)
            begin
                post_random();
            end
            if (ph == 2)
            begin
                hold_kick++;
            end
            drain();
        end

        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        repeat (10) @(posedge clk);
        if (err_cnt == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/cqc_pkg.sv
hdl/cqc_regs.sv
hdl/cqc_in_reg.sv
hdl/cqc_core.sv
hdl/clamped_quadrature_counter_unit.sv
hdl/cqc_checker.sv
tb/clamped_quadrature_counter_unit_tb.sv
